### rtl/core/oidber_pkg.sv
// ----------------------------------------------------------------------------
// oidber_pkg: shared types and constants of the OID arc BER encoder
// Holds the job record passed from the front end to the back end, the arc
// phase type and the helpers that split an arc value into base-128 groups.
// ----------------------------------------------------------------------------
package oidber_pkg;

    // Width of an input arc and of a combined head arc (first * 40 + second).
    localparam int C_ARC_W     = 32;
    localparam int C_VALUE_W   = 38;
    localparam int C_GROUP_W   = 7;
    localparam int C_MAX_GROUPS = 6;
    localparam int C_EXT_W     = C_GROUP_W * C_MAX_GROUPS;

    localparam logic [5:0] C_HEAD_MULT = 6'd40;
    localparam logic [7:0] C_MORE_BIT  = 8'h80;
    localparam logic [C_GROUP_W-1:0] C_GROUP_MASK = 7'h7f;

    // Position of the incoming arc within the identifier.
    typedef enum logic [1:0] {
        PH_FIRST  = 2'd0,
        PH_SECOND = 2'd1,
        PH_LATER  = 2'd2
    } t_phase;

    // One encode job: a value plus the index of its most significant group.
    typedef struct packed {
        logic [C_VALUE_W-1:0] value;
        logic [2:0]           grp_msb;
        logic                 final_arc;
        logic                 too_short;
    } t_arc_job;

    // Index of the highest non-zero base-128 group (zero for a zero value).
    function automatic logic [2:0] f_group_msb(input logic [C_VALUE_W-1:0] v);
        logic [C_EXT_W-1:0] ext;
        logic [2:0]         msb;
        ext = C_EXT_W'(v);
        msb = 3'd0;
        for (int k = 1; k < C_MAX_GROUPS; k++) begin
            if (|ext[C_GROUP_W*k +: C_GROUP_W]) begin
                msb = 3'(k);
            end
        end
        return msb;
    endfunction

    // Base-128 group number idx of a value.
    function automatic logic [C_GROUP_W-1:0] f_group(input logic [C_VALUE_W-1:0] v,
                                                     input logic [2:0] idx);
        logic [C_EXT_W-1:0]   ext;
        logic [C_GROUP_W-1:0] grp;
        ext = C_EXT_W'(v);
        grp = '0;
        for (int k = 0; k < C_MAX_GROUPS; k++) begin
            if (idx == 3'(k)) begin
                grp = ext[C_GROUP_W*k +: C_GROUP_W] & C_GROUP_MASK;
            end
        end
        return grp;
    endfunction

endpackage

### rtl/core/oidber_front.sv
// ----------------------------------------------------------------------------
// oidber_front: arc intake and classification
// Tracks the arc phase, holds the first arc, forms the combined head arc and
// turns every arc that produces output into an encode job for the queue.
// ----------------------------------------------------------------------------
module oidber_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic [oidber_pkg::C_ARC_W-1:0] i_arc_value,
    input  logic                       i_last_arc,
    input  logic                       i_q_full,
    output logic                       o_job_valid,
    output oidber_pkg::t_arc_job       o_job
);
    import oidber_pkg::*;

    t_phase             r_phase;
    t_phase             n_phase;
    logic [C_ARC_W-1:0] r_held;
    logic               w_accept;
    logic [C_VALUE_W-1:0] w_head;
    logic [C_VALUE_W-1:0] w_value;

    // A request is taken whenever the job queue has room.
    assign full     = i_q_full;
    assign w_accept = push && !i_q_full;

    // Head arc: held first arc times forty plus the second arc.
    assign w_head = C_VALUE_W'(r_held) * C_VALUE_W'(C_HEAD_MULT) + C_VALUE_W'(i_arc_value);

    // Next phase.
    always_comb begin
        n_phase = r_phase;
        if (w_accept) begin
            if (i_last_arc) begin
                n_phase = PH_FIRST;
            end else if (r_phase == PH_FIRST) begin
                n_phase = PH_SECOND;
            end else begin
                n_phase = PH_LATER;
            end
        end
    end

    // Job generation. A first arc that is not also the last gives no job.
    always_comb begin
        o_job_valid = 1'b0;
        w_value     = '0;
        o_job       = '0;
        case (r_phase)
            PH_FIRST: begin
                o_job_valid     = w_accept && i_last_arc;
                o_job.too_short = 1'b1;
            end
            PH_SECOND: begin
                o_job_valid = w_accept;
                w_value     = w_head;
            end
            default: begin
                o_job_valid = w_accept;
                w_value     = C_VALUE_W'(i_arc_value);
            end
        endcase
        o_job.value     = w_value;
        o_job.grp_msb   = f_group_msb(w_value);
        o_job.final_arc = i_last_arc;
    end

    // Phase register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_FIRST;
        end else begin
            r_phase <= n_phase;
        end
    end

    // The first arc is kept for the head arc.
    always_ff @(posedge i_clk) begin
        if (w_accept && r_phase == PH_FIRST) begin
            r_held <= i_arc_value;
        end
    end

endmodule

### rtl/core/oidber_queue.sv
// ----------------------------------------------------------------------------
// oidber_queue: job queue between front end and back end
// A small circular buffer of encode jobs; the head entry is shown directly.
// ----------------------------------------------------------------------------
module oidber_queue #(
    parameter int P_DEPTH = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr,
    input  oidber_pkg::t_arc_job i_wr_job,
    output logic                 o_full,
    input  logic                 i_rd,
    output logic                 o_empty,
    output oidber_pkg::t_arc_job o_rd_job
);
    import oidber_pkg::*;

    localparam int PW = $clog2(P_DEPTH);
    localparam int CW = $clog2(P_DEPTH + 1);
    localparam logic [PW-1:0] C_LAST_PTR = PW'(P_DEPTH - 1);
    localparam logic [CW-1:0] C_FULL_CNT = CW'(P_DEPTH);

    t_arc_job      r_mem [P_DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          w_wr;
    logic          w_rd;

    assign o_full   = (r_count == C_FULL_CNT);
    assign o_empty  = (r_count == '0);
    assign w_wr     = i_wr && !o_full;
    assign w_rd     = i_rd && !o_empty;
    assign o_rd_job = r_mem[r_rd_ptr];

    // Pointer and fill count update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= (r_wr_ptr == C_LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == C_LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_wr_job;
        end
    end

endmodule

### rtl/core/oidber_back.sv
// ----------------------------------------------------------------------------
// oidber_back: octet serializer
// Walks the groups of the head job from the most significant one down and places
// one content octet per cycle in the output register when it is free or drained.
// ----------------------------------------------------------------------------
module oidber_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_job_valid,
    input  oidber_pkg::t_arc_job i_job,
    output logic                 o_job_pop,
    output logic                 empty,
    input  logic                 pop,
    output logic [7:0]           o_octet,
    output logic                 o_arc_end,
    output logic                 o_oid_end,
    output logic                 o_too_short
);
    import oidber_pkg::*;

    logic                 r_out_valid;
    logic [7:0]           r_octet;
    logic                 r_arc_end;
    logic                 r_oid_end;
    logic                 r_too_short;
    logic [2:0]           r_cnt;
    logic                 w_adv;
    logic                 w_emit;
    logic                 w_last;
    logic [2:0]           w_idx;
    logic [C_GROUP_W-1:0] w_grp;

    // The output register can load when it is free or being drained.
    assign w_adv     = !r_out_valid || pop;
    assign w_emit    = w_adv && i_job_valid;
    assign w_last    = (r_cnt == i_job.grp_msb);
    assign w_idx     = i_job.grp_msb - r_cnt;
    assign w_grp     = f_group(i_job.value, w_idx);
    assign o_job_pop = w_emit && w_last;

    assign empty       = !r_out_valid;
    assign o_octet     = r_octet;
    assign o_arc_end   = r_arc_end;
    assign o_oid_end   = r_oid_end;
    assign o_too_short = r_too_short;

    // Group counter and output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_emit) begin
                r_cnt <= w_last ? 3'd0 : r_cnt + 3'd1;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output payload: the continuation bit is set on all but the last group.
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_octet     <= w_last ? {1'b0, w_grp} : (C_MORE_BIT | {1'b0, w_grp});
            r_arc_end   <= w_last;
            r_oid_end   <= w_last && i_job.final_arc;
            r_too_short <= i_job.too_short;
        end
    end

endmodule

### rtl/core/oid_arc_ber_encoder_top.sv
// Path: each job passes from the job queue into the output register to be seen.
// Throughput: one octet per cycle on the result side while pop drains the output
// register; an arc gives one octet per base-128 group, one to six groups. Intake
// continues while the job queue (P_QUEUE_DEPTH entries) has room.
// Reset: synchronous, active low; clears phase, queue and output valid state.
// ----------------------------------------------------------------------------
// oid_arc_ber_encoder_top: OID arc to BER content octet encoder
// Front end classifies arcs and builds jobs, a queue decouples it from the
// back end, which serializes each job into content octets.
// ----------------------------------------------------------------------------
module oid_arc_ber_encoder_top #(
    parameter int P_QUEUE_DEPTH = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic [oidber_pkg::C_ARC_W-1:0] i_arc_value,
    input  logic                           i_last_arc,
    output logic                           empty,
    input  logic                           pop,
    output logic [7:0]                     o_octet,
    output logic                           o_arc_end,
    output logic                           o_oid_end,
    output logic                           o_too_short
);
    import oidber_pkg::*;

    logic     w_q_full;
    logic     w_wr;
    t_arc_job w_wr_job;
    logic     w_q_empty;
    t_arc_job w_rd_job;
    logic     w_job_pop;

    // Arc intake.
    oidber_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_arc_value (i_arc_value),
        .i_last_arc  (i_last_arc),
        .i_q_full    (w_q_full),
        .o_job_valid (w_wr),
        .o_job       (w_wr_job)
    );

    // Job queue.
    oidber_queue #(
        .P_DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (w_wr),
        .i_wr_job (w_wr_job),
        .o_full   (w_q_full),
        .i_rd     (w_job_pop),
        .o_empty  (w_q_empty),
        .o_rd_job (w_rd_job)
    );

    // Octet serializer.
    oidber_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (!w_q_empty),
        .i_job       (w_rd_job),
        .o_job_pop   (w_job_pop),
        .empty       (empty),
        .pop         (pop),
        .o_octet     (o_octet),
        .o_arc_end   (o_arc_end),
        .o_oid_end   (o_oid_end),
        .o_too_short (o_too_short)
    );

`ifndef SYNTH
    // The serializer only retires a job that the queue holds.
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_job_pop |-> !w_q_empty)
        else $error("job retired from an empty queue");

    // A single-arc job carries exactly one zero group.
    a_short_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_wr && w_wr_job.too_short) |-> (w_wr_job.grp_msb == 3'd0 && w_wr_job.value == '0))
        else $error("malformed single-arc job");

    // No job needs more than six groups.
    a_grp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr |-> (w_wr_job.grp_msb < 3'(C_MAX_GROUPS)))
        else $error("group count out of range");

    // The continuation bit is set exactly on octets that do not end an arc.
    a_more_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_octet[7] == !o_arc_end))
        else $error("continuation bit disagrees with arc end");

    // The single-arc result is a lone zero octet ending the identifier.
    a_short_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_too_short) |-> (o_arc_end && o_oid_end && o_octet == 8'h00))
        else $error("malformed single-arc result");
`endif

endmodule

### verif/oid_arc_ber_encoder_checker.sv
// ----------------------------------------------------------------------------
// oid_arc_ber_encoder_checker: result predictor and comparator
// Watches the arc request channel and the octet result channel of the OID
// arc encoder, predicts the BER content octets of every accepted arc and
// compares each popped octet field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module oid_arc_ber_encoder_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  logic        i_full,
    input  logic [31:0] i_arc_value,
    input  logic        i_last_arc,
    input  logic        i_empty,
    input  logic        i_pop,
    input  logic [7:0]  i_octet,
    input  logic        i_arc_end,
    input  logic        i_oid_end,
    input  logic        i_too_short,
    output int          o_fail_count,
    output int          o_pending
);

    localparam logic [37:0] ARC_MULT   = 38'd40;
    localparam logic [7:0]  CONT_BIT   = 8'h80;
    localparam logic [6:0]  GROUP_BITS = 7'h7f;
    localparam int          MAX_GROUPS = 6;

    // One predicted content octet with its flags.
    typedef struct packed {
        logic [7:0] octet;
        logic       arc_end;
        logic       oid_end;
        logic       too_short;
    } t_octet_rec;

    t_octet_rec          expected_octets[$];
    oidber_pkg::t_phase  arc_phase;
    logic [31:0]         held_first_arc;

    // Print one line per failure and count it.
    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        o_fail_count++;
    endtask

    // Queue the base-128 groups of a value, most significant group first.
    function automatic void queue_groups(input logic [37:0] value, input logic final_arc);
        int         n;
        logic [6:0] grp;
        t_octet_rec rec;
        n = 1;
        while (n < MAX_GROUPS && (value >> (7 * n)) != 38'd0) begin
            n++;
        end
        for (int k = n - 1; k >= 0; k--) begin
            grp           = 7'(value >> (7 * k)) & GROUP_BITS;
            rec.octet     = (k == 0) ? {1'b0, grp} : ({1'b0, grp} | CONT_BIT);
            rec.arc_end   = (k == 0);
            rec.oid_end   = (k == 0) && final_arc;
            rec.too_short = 1'b0;
            expected_octets.push_back(rec);
        end
    endfunction

    // Advance the arc position and predict the octets of one arc request.
    function automatic void encode_request(input logic [31:0] arc, input logic last);
        logic [37:0] head;
        t_octet_rec  rec;
        case (arc_phase)
            oidber_pkg::PH_FIRST: begin
                held_first_arc = arc;
                if (last) begin
                    // An identifier of one arc gives a lone error octet.
                    rec.octet     = 8'h00;
                    rec.arc_end   = 1'b1;
                    rec.oid_end   = 1'b1;
                    rec.too_short = 1'b1;
                    expected_octets.push_back(rec);
                end else begin
                    arc_phase = oidber_pkg::PH_SECOND;
                end
            end
            oidber_pkg::PH_SECOND: begin
                // The head arc is first * 40 + second at full width.
                head = 38'(held_first_arc) * ARC_MULT + 38'(arc);
                queue_groups(head, last);
                arc_phase = last ? oidber_pkg::PH_FIRST : oidber_pkg::PH_LATER;
            end
            default: begin
                queue_groups(38'(arc), last);
                arc_phase = last ? oidber_pkg::PH_FIRST : oidber_pkg::PH_LATER;
            end
        endcase
    endfunction

    // Compare one accepted result with the oldest prediction.
    task automatic check_octet();
        t_octet_rec want;
        if (expected_octets.size() == 0) begin
            report_mismatch($sformatf("result with no request pending, octet %02h", i_octet));
            return;
        end
        want = expected_octets.pop_front();
        if (i_octet !== want.octet) begin
            report_mismatch($sformatf("octet expected %02h, got %02h", want.octet, i_octet));
        end
        if (i_arc_end !== want.arc_end) begin
            report_mismatch($sformatf("arc_end expected %0b, got %0b", want.arc_end, i_arc_end));
        end
        if (i_oid_end !== want.oid_end) begin
            report_mismatch($sformatf("oid_end expected %0b, got %0b", want.oid_end, i_oid_end));
        end
        if (i_too_short !== want.too_short) begin
            report_mismatch($sformatf("too_short expected %0b, got %0b",
                                      want.too_short, i_too_short));
        end
    endtask

    initial begin
        o_fail_count   = 0;
        o_pending      = 0;
        arc_phase      = oidber_pkg::PH_FIRST;
        held_first_arc = '0;
    end

    // Sample both channels at the rising edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            arc_phase      = oidber_pkg::PH_FIRST;
            held_first_arc = '0;
            expected_octets.delete();
        end else begin
            if (i_push && !i_full) begin
                encode_request(i_arc_value, i_last_arc);
            end
            if (i_pop && !i_empty) begin
                check_octet();
            end
        end
        o_pending = expected_octets.size();
    end

endmodule

### verif/oid_arc_ber_encoder_top_test.sv
// ----------------------------------------------------------------------------
// oid_arc_ber_encoder_top_test: testbench top of the OID arc encoder
// Drives directed and random object identifiers into the encoder with random
// gaps, pops octets with random stalls and one long hold-off, and reports
// the verdict from the failure count of the checker.
// ----------------------------------------------------------------------------
module oid_arc_ber_encoder_top_test;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [31:0] arc_value;
    logic        last_arc;
    logic        empty;
    logic        pop;
    logic [7:0]  octet;
    logic        arc_end;
    logic        oid_end;
    logic        too_short;

    int fail_count;
    int pending;
    bit idle_en;
    bit start_hold;

    oid_arc_ber_encoder_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_arc_value (arc_value),
        .i_last_arc  (last_arc),
        .empty       (empty),
        .pop         (pop),
        .o_octet     (octet),
        .o_arc_end   (arc_end),
        .o_oid_end   (oid_end),
        .o_too_short (too_short)
    );

    oid_arc_ber_encoder_checker u_scoreboard (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_full       (full),
        .i_arc_value  (arc_value),
        .i_last_arc   (last_arc),
        .i_empty      (empty),
        .i_pop        (pop),
        .i_octet      (octet),
        .i_arc_end    (arc_end),
        .i_oid_end    (oid_end),
        .i_too_short  (too_short),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Overall time limit of the run.
    initial begin
        #(20 * 200000);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Arc value of random magnitude, so that every group count occurs.
    function automatic logic [31:0] random_arc();
        int unsigned bits;
        bits = $urandom_range(32);
        if (bits == 0) begin
            return 32'd0;
        end
        return $urandom >> (32 - bits);
    endfunction

    // Offer one arc request and hold it until it is taken.
    // Called and left at a falling edge.
    task automatic send_arc(input logic [31:0] arc, input logic final_flag);
        if (idle_en && $urandom_range(99) < 28) begin
            push <= 1'b0;
            @(negedge i_clk);
            while (idle_en && $urandom_range(99) < 28) begin
                @(negedge i_clk);
            end
        end
        push      <= 1'b1;
        arc_value <= arc;
        last_arc  <= final_flag;
        @(posedge i_clk);
        while (full) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    // Result side: random stalls and one long hold-off on request.
    initial begin : receiver
        int  hold_left;
        bit  hold_done;
        pop       = 1'b0;
        hold_left = 0;
        hold_done = 1'b0;
        @(negedge i_clk);
        while (!i_rst_n) begin
            @(negedge i_clk);
        end
        forever begin
            if (start_hold && !hold_done) begin
                hold_done = 1'b1;
                hold_left = 160;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                pop <= !(idle_en && $urandom_range(99) < 28);
            end
            @(negedge i_clk);
        end
    end

    // Stimulus and verdict.
    initial begin : stimulus
        int          sent;
        int          len;
        logic [31:0] v;
        i_rst_n    = 1'b0;
        push       = 1'b0;
        arc_value  = '0;
        last_arc   = 1'b0;
        idle_en    = 1'b1;
        start_hold = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Identifiers of a single arc, smallest and largest.
        send_arc(32'd0, 1'b1);
        send_arc(32'hffff_ffff, 1'b1);
        // Head arc of zero.
        send_arc(32'd0, 1'b0);
        send_arc(32'd0, 1'b1);
        // Top of the published ranges, then group boundaries of later arcs.
        send_arc(32'd2, 1'b0);
        send_arc(32'd39, 1'b0);
        send_arc(32'd0, 1'b0);
        send_arc(32'd127, 1'b0);
        send_arc(32'd128, 1'b0);
        send_arc(32'hffff_ffff, 1'b1);
        // Largest head arc, which needs six groups.
        send_arc(32'hffff_ffff, 1'b0);
        send_arc(32'hffff_ffff, 1'b0);
        send_arc(32'd16383, 1'b0);
        send_arc(32'd16384, 1'b0);
        send_arc(32'h001f_ffff, 1'b0);
        send_arc(32'h0020_0000, 1'b0);
        send_arc(32'h0fff_ffff, 1'b0);
        send_arc(32'h1000_0000, 1'b0);
        send_arc(32'h5555_5555, 1'b0);
        send_arc(32'haaaa_aaaa, 1'b1);
        // Short identifier with a zero second arc.
        send_arc(32'd1, 1'b0);
        send_arc(32'd0, 1'b1);

        // Random identifiers, mostly well formed, some of a single arc.
        sent = 0;
        while (sent < 160) begin
            idle_en = !(sent >= 90 && sent < 140);
            if (sent >= 30) begin
                start_hold = 1'b1;
            end
            if ($urandom_range(99) < 12) begin
                send_arc(random_arc(), 1'b1);
                sent++;
            end else begin
                len = $urandom_range(8, 2);
                for (int k = 0; k < len; k++) begin
                    if (k == 0) begin
                        v = $urandom_range(1) ? 32'($urandom_range(2)) : random_arc();
                    end else if (k == 1) begin
                        v = $urandom_range(1) ? 32'($urandom_range(39)) : random_arc();
                    end else begin
                        v = random_arc();
                    end
                    send_arc(v, k == len - 1);
                    sent++;
                end
            end
        end
        push    <= 1'b0;
        idle_en = 1'b1;

        // Drain all predicted octets, then watch for stray results.
        while (pending != 0) begin
            @(negedge i_clk);
        end
        repeat (10) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
